// File: rtl/rcfd_pkg.sv
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the serial RC frame decoder.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Frame geometry
    localparam int FRAME_LENGTH    = 16;
    localparam int SLOTS_PER_FRAME = 7;

    // Byte store: even bytes in one bank, odd bytes in the other
    localparam int BANK_DEPTH = (FRAME_LENGTH + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int COUNT_W    = $clog2(FRAME_LENGTH);
    localparam int SLOT_W     = (SLOTS_PER_FRAME > 1) ? $clog2(SLOTS_PER_FRAME) : 1;
    localparam int POS_W      = $clog2(2 * SLOTS_PER_FRAME + FRAME_LENGTH + 2);

    // Decode constants
    localparam logic [15:0] PAD_WORD   = 16'hffff;
    localparam logic [10:0] PULSE_BASE = 11'd988;

    // Configuration register indexes
    localparam logic [1:0] CFG_ELEVEN_BIT = 2'd0;
    localparam logic [1:0] CFG_GAP_US     = 2'd1;
    localparam logic [1:0] CFG_CH_LIMIT   = 2'd2;

    // Configuration reset values
    localparam logic [15:0] GAP_US_RESET   = 16'd5000;
    localparam logic [4:0]  CH_LIMIT_RESET = 5'd8;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_time_us;
    } t_in_word;

    typedef struct packed {
        logic        slot_valid;
        logic [3:0]  channel_index;
        logic [10:0] pulse_value;
        logic [3:0]  highest_channel;
        logic        last_of_frame;
    } t_out_word;

    typedef enum logic {
        ST_COLLECT,
        ST_DECODE
    } t_state;

endpackage

// File: rtl/rc_serial_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_core
// Serial RC receiver frame assembler and channel word decoder.
// Output: once the byte completing a frame is taken, the decode state loads
//   one slot word per cycle (7 words) into the output register when the sink
//   keeps up. Throughput: one byte per cycle while collecting; after the final
//   byte of a frame no byte is taken until the seventh slot word is loaded.
// Reset: synchronous active-low; config back to defaults, byte count, last
//   byte time and highest channel cleared. Frame store is not cleared.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_core
    import rcfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // byte input
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    // slot output
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data,
    // configuration writes
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers (always writable, not enforced; the user must write them only when idle)
    // ------------------------------------------------------------------
    logic        r_eleven_bit;
    logic [15:0] r_gap_us;
    logic [4:0]  r_ch_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eleven_bit <= 1'b1;
            r_gap_us     <= GAP_US_RESET;
            r_ch_limit   <= CH_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ELEVEN_BIT: r_eleven_bit <= i_cfg_data[0];
                CFG_GAP_US:     r_gap_us     <= i_cfg_data;
                CFG_CH_LIMIT:   r_ch_limit   <= i_cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [31:0]        r_last_time;
    logic [3:0]         r_highest, n_highest;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_out_valid;
    t_out_word          r_out, n_out;

    logic               in_acc;
    logic               gap_hit;
    logic [COUNT_W-1:0] wr_pos;
    logic               frame_done;
    logic               out_free;
    logic               load;
    logic               last_slot;

    assign o_in_ready  = (r_state == ST_COLLECT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // gap measured from previous byte, wrap-safe subtract
    assign gap_hit    = (i_in_data.arrival_time_us - r_last_time) > {16'd0, r_gap_us};
    assign wr_pos     = gap_hit ? '0 : r_count;
    assign frame_done = (wr_pos == COUNT_W'(FRAME_LENGTH - 1));

    assign out_free  = !r_out_valid || i_out_ready;
    assign last_slot = (r_slot == SLOT_W'(SLOTS_PER_FRAME - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_acc && frame_done) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (out_free && last_slot) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        load    = (r_state == ST_DECODE) && out_free;
        n_count = r_count;
        n_slot  = r_slot;
        if (in_acc) begin
            n_count = frame_done ? '0 : wr_pos + COUNT_W'(1);
            n_slot  = '0;
        end
        if (load && !last_slot) begin
            n_slot = r_slot + SLOT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Frame store: read address follows the next slot, so the read data
    // matches r_slot in the decode state. A stall re-reads the same word.
    // ------------------------------------------------------------------
    logic [POS_W-1:0]   rd_word;
    logic [BANK_AW-1:0] rd_addr;
    logic [7:0]         rd_even, rd_odd;

    assign rd_word = POS_W'(n_slot) + POS_W'(1);
    assign rd_addr = (rd_word < POS_W'(BANK_DEPTH)) ? BANK_AW'(rd_word) : '0;

    rcfd_frame_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc),
        .i_wr_pos  (wr_pos),
        .i_wr_data (i_in_data.rx_byte),
        .i_rd_addr (rd_addr),
        .o_rd_even (rd_even),
        .o_rd_odd  (rd_odd)
    );

    // ------------------------------------------------------------------
    // Slot decode
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_even;
    logic [15:0]      word;
    logic [3:0]       idx;
    logic [9:0]       data;
    logic             valid;

    assign pos_even = (POS_W'(r_slot) << 1) + POS_W'(2);

    always_comb begin
        // bytes past the frame read as zero
        word[15:8] = (pos_even < POS_W'(FRAME_LENGTH)) ? rd_even : 8'd0;
        word[7:0]  = ((pos_even + POS_W'(1)) < POS_W'(FRAME_LENGTH)) ? rd_odd : 8'd0;
        idx        = r_eleven_bit ? word[14:11] : word[13:10];
        data       = r_eleven_bit ? word[10:1] : word[9:0];
        valid      = (word != PAD_WORD) && ({1'b0, idx} < r_ch_limit);
        n_highest  = (valid && idx > r_highest) ? idx : r_highest;

        n_out.slot_valid      = valid;
        n_out.channel_index   = valid ? idx : 4'd0;
        n_out.pulse_value     = valid ? PULSE_BASE + {1'b0, data} : 11'd0;
        n_out.highest_channel = n_highest;
        n_out.last_of_frame   = last_slot;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_count     <= '0;
            r_last_time <= '0;
            r_highest   <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_slot  <= n_slot;
            if (in_acc) begin
                r_last_time <= i_in_data.arrival_time_us;
            end
            if (load) begin
                r_highest   <= n_highest;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/rcfd_frame_store.sv
// ----------------------------------------------------------------------------
// rcfd_frame_store
// Frame byte store, split into even and odd banks so a whole 16-bit word
// comes out in one read. Registered read.
// ----------------------------------------------------------------------------
module rcfd_frame_store
    import rcfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_wr_en,
    input  logic [COUNT_W-1:0] i_wr_pos,
    input  logic [7:0]         i_wr_data,
    input  logic [BANK_AW-1:0] i_rd_addr,
    output logic [7:0]         o_rd_even,
    output logic [7:0]         o_rd_odd
);

    logic [7:0] r_even [BANK_DEPTH];
    logic [7:0] r_odd  [BANK_DEPTH];
    logic [BANK_AW-1:0] wr_addr;

    assign wr_addr = BANK_AW'(i_wr_pos >> 1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_pos[0]) begin
            r_even[wr_addr] <= i_wr_data;
        end
        if (i_wr_en && i_wr_pos[0]) begin
            r_odd[wr_addr] <= i_wr_data;
        end
        o_rd_even <= r_even[i_rd_addr];
        o_rd_odd  <= r_odd[i_rd_addr];
    end

endmodule
